// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/biq_pkg.sv =====
// Shared types, constants and rounding helpers of the biquad section.
// No dependencies.
package biq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int STATE_BITS  = 32;
  localparam int CF          = COEF_BITS - 3;
  localparam int PROD_BITS   = COEF_BITS + STATE_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PDATA_BITS  = 32;
  localparam int ADDR_BITS   = 5;
  localparam int NUM_REGS    = 5;

  // 1.0 in coefficient format, used to scale the input sample
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = {3'b001, {CF{1'b0}}};
  localparam logic signed [ACC_BITS-1:0]  ACC_HALF =
    {{(ACC_BITS-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0]  ST_MAX =
    {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_BITS-1:0]  SMP_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]  SMP_MIN = ~SMP_MAX;

  typedef enum logic [2:0] {
    REG_FB1 = 3'd0,
    REG_FB2 = 3'd1,
    REG_FF0 = 3'd2,
    REG_FF1 = 3'd3,
    REG_FF2 = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MZ1A,
    ST_MZ2A,
    ST_WACC,
    ST_WRND,
    ST_MW,
    ST_MZ1B,
    ST_MZ2B,
    ST_YACC,
    ST_YRND
  } state_e;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] fb1;
    logic signed [COEF_BITS-1:0] fb2;
    logic signed [COEF_BITS-1:0] ff0;
    logic signed [COEF_BITS-1:0] ff1;
    logic signed [COEF_BITS-1:0] ff2;
  } coefs_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sat;
    logic                          last;
  } res_t;

  typedef struct packed {
    logic                         clip;
    logic signed [STATE_BITS-1:0] val;
  } w_res_t;

  typedef struct packed {
    logic                          clip;
    logic signed [SAMPLE_BITS-1:0] val;
  } y_res_t;

  // Round half up at bit CF, then clamp to the delay word range
  function automatic w_res_t round_state(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] s;
    w_res_t r;
    s = (acc + ACC_HALF) >>> CF;
    if (s > ST_MAX) begin
      r.clip = 1'b1;
      r.val  = ST_MAX[STATE_BITS-1:0];
    end else if (s < ST_MIN) begin
      r.clip = 1'b1;
      r.val  = ST_MIN[STATE_BITS-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = s[STATE_BITS-1:0];
    end
    return r;
  endfunction

  // Round half up at bit CF, then clamp to the sample range
  function automatic y_res_t round_sample(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] s;
    y_res_t r;
    s = (acc + ACC_HALF) >>> CF;
    if (s > SMP_MAX) begin
      r.clip = 1'b1;
      r.val  = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (s < SMP_MIN) begin
      r.clip = 1'b1;
      r.val  = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = s[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/biq_regs.sv =====
// APB coefficient register file of the biquad section.
// Depends on biq_pkg.
module biq_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [biq_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [biq_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [biq_pkg::PDATA_BITS-1:0]   prdata,
  output logic                             pready,
  output biq_pkg::coefs_t                  coefs_o,
  output logic                             clear_o
);
  import biq_pkg::*;

  coefs_t   coefs_d, coefs_q;
  reg_idx_e idx;
  logic     wr_en;
  logic     hit;
  logic signed [COEF_BITS-1:0] rd_coef;
  logic signed [COEF_BITS-1:0] wr_coef;

  assign pready  = 1'b1;
  assign idx     = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign wr_coef = pwdata[COEF_BITS-1:0];

  // read select and write decode
  always_comb begin
    coefs_d = coefs_q;
    hit     = 1'b1;
    rd_coef = '0;
    case (idx)
      REG_FB1: begin
        rd_coef = coefs_q.fb1;
        if (wr_en) coefs_d.fb1 = wr_coef;
      end
      REG_FB2: begin
        rd_coef = coefs_q.fb2;
        if (wr_en) coefs_d.fb2 = wr_coef;
      end
      REG_FF0: begin
        rd_coef = coefs_q.ff0;
        if (wr_en) coefs_d.ff0 = wr_coef;
      end
      REG_FF1: begin
        rd_coef = coefs_q.ff1;
        if (wr_en) coefs_d.ff1 = wr_coef;
      end
      REG_FF2: begin
        rd_coef = coefs_q.ff2;
        if (wr_en) coefs_d.ff2 = wr_coef;
      end
      default: hit = 1'b0;
    endcase
  end

  // any write to a real register clears the delay line
  assign clear_o = wr_en & hit;
  assign prdata  = PDATA_BITS'($unsigned(rd_coef));
  assign coefs_o = coefs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= '0;
    end else begin
      coefs_q <= coefs_d;
    end
  end

endmodule

// ===== rtl/core/biq_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on biq_pkg.
module biq_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [biq_pkg::COEF_BITS-1:0]  a_i,
  input  logic signed [biq_pkg::STATE_BITS-1:0] b_i,
  input  biq_pkg::mac_ctl_t                   ctl_i,
  output logic signed [biq_pkg::ACC_BITS-1:0]   acc_o
);
  import biq_pkg::*;

  logic signed [PROD_BITS-1:0] prod_q;
  mac_ctl_t                    ctl_q;
  logic signed [ACC_BITS-1:0]  acc_d, acc_q;
  logic signed [ACC_BITS-1:0]  base;
  logic signed [ACC_BITS-1:0]  term;

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // accumulate stage
  always_comb begin
    base  = ctl_q.clear ? '0 : acc_q;
    term  = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
    acc_d = acc_q;
    if (ctl_q.valid) begin
      acc_d = ctl_q.sub ? (base - term) : (base + term);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/biq_seq.sv =====
// Sequencer of the biquad section: operand selection, delay words, rounding.
// Depends on biq_pkg; drives biq_mac.
module biq_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [biq_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic                                  in_last_i,
  input  biq_pkg::coefs_t                       coefs_i,
  input  logic                                  clear_i,
  input  logic                                  out_free_i,
  input  logic signed [biq_pkg::ACC_BITS-1:0]   acc_i,
  output logic signed [biq_pkg::COEF_BITS-1:0]  mac_a_o,
  output logic signed [biq_pkg::STATE_BITS-1:0] mac_b_o,
  output biq_pkg::mac_ctl_t                     mac_ctl_o,
  output biq_pkg::res_t                         res_o
);
  import biq_pkg::*;

  state_e state_d, state_q;
  logic signed [STATE_BITS-1:0] x_q;
  logic                         last_q;
  logic signed [STATE_BITS-1:0] z1_q, z2_q;
  logic signed [STATE_BITS-1:0] w_q;
  logic                         wclip_q;
  w_res_t                       w_res;
  y_res_t                       y_res;
  logic                         accept;

  assign w_res  = round_state(acc_i);
  assign y_res  = round_sample(acc_i);
  assign accept = in_valid_i & in_ready_o;

  // next state, operand select and MAC control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mac_a_o    = COEF_ONE;
    mac_b_o    = x_q;
    mac_ctl_o  = '0;
    res_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_MX;
      end
      ST_MX: begin
        mac_ctl_o = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
        state_d   = ST_MZ1A;
      end
      ST_MZ1A: begin
        mac_a_o   = coefs_i.fb1;
        mac_b_o   = z1_q;
        mac_ctl_o = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
        state_d   = ST_MZ2A;
      end
      ST_MZ2A: begin
        mac_a_o   = coefs_i.fb2;
        mac_b_o   = z2_q;
        mac_ctl_o = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
        state_d   = ST_WACC;
      end
      ST_WACC: state_d = ST_WRND;
      ST_WRND: state_d = ST_MW;
      ST_MW: begin
        mac_a_o   = coefs_i.ff0;
        mac_b_o   = w_q;
        mac_ctl_o = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
        state_d   = ST_MZ1B;
      end
      ST_MZ1B: begin
        mac_a_o   = coefs_i.ff1;
        mac_b_o   = z1_q;
        mac_ctl_o = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
        state_d   = ST_MZ2B;
      end
      ST_MZ2B: begin
        mac_a_o   = coefs_i.ff2;
        mac_b_o   = z2_q;
        mac_ctl_o = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
        state_d   = ST_YACC;
      end
      ST_YACC: state_d = ST_YRND;
      ST_YRND: begin
        // hold here until the output register can take the result
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.sample = y_res.val;
          res_o.sat    = wclip_q | y_res.clip;
          res_o.last   = last_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // captured input and intermediate w
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= STATE_BITS'(in_sample_i);
      last_q <= in_last_i;
    end
    if (state_q == ST_WRND) begin
      w_q     <= w_res.val;
      wclip_q <= w_res.clip;
    end
  end

  // delay line: shift on completion, clear on coefficient write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (clear_i) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (res_o.valid) begin
      z1_q <= w_q;
      z2_q <= z1_q;
    end
  end

endmodule

// ===== rtl/core/biquad_iir_filter.sv =====
// Biquad IIR section, direct form II, with one shared multiply-accumulate.
// From input transfer to output tvalid: six MAC passes, two MAC drain states and two
// rounding states, then the output register.
// No new sample is taken until the last result enters the output register; stalls delay it.
// Reset: async active low; clears coefficients, delay words and control.
// Top level; depends on biq_pkg, biq_regs, biq_mac, biq_seq.
module biquad_iir_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // stream input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [biq_pkg::TDATA_BITS-1:0]       s_axis_tdata,  // [23:0] sample_in
  input  logic                                 s_axis_tlast,  // last_in_block
  // stream output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [biq_pkg::TDATA_BITS-1:0]       m_axis_tdata,  // [23:0] sample_out
  output logic                                 m_axis_tuser,  // saturated
  output logic                                 m_axis_tlast,  // last_out
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [biq_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [biq_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [biq_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import biq_pkg::*;

  coefs_t                       coefs;
  logic                         clear;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [COEF_BITS-1:0]  mac_a;
  logic signed [STATE_BITS-1:0] mac_b;
  mac_ctl_t                     mac_ctl;
  res_t                         res;
  logic                         out_free;
  logic                         out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                         out_sat_q;
  logic                         out_last_q;

  biq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs_o (coefs),
    .clear_o (clear)
  );

  biq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  biq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last_i   (s_axis_tlast),
    .coefs_i     (coefs),
    .clear_i     (clear),
    .out_free_i  (out_free),
    .acc_i       (acc),
    .mac_a_o     (mac_a),
    .mac_b_o     (mac_b),
    .mac_ctl_o   (mac_ctl),
    .res_o       (res)
  );

  // output register, free when empty or being drained this cycle
  assign out_free = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_sample_q <= res.sample;
      out_sat_q    <= res.sat;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_BITS'($unsigned(out_sample_q));
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/biq_checker.sv =====
// Port-level checker for the biquad section, bound to the top level.
// Depends on biq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module biq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [biq_pkg::TDATA_BITS-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast,
  input logic                            pready
);
  import biq_pkg::*;

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // one sample at a time: busy right after an input transfer
  `ASSERT_CLK(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // configuration port never waits
  `ASSERT_NEVER(a_pready_low, clk_i, rst_ni, !pready)

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (.*);

// ===== tb/tb_biquad_iir_filter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the biquad IIR section: samples go in over the input stream,
// coefficients over APB; each output is checked against a fixed-point model or the plan.
// Depends on biq_pkg and the biquad_iir_filter RTL.

module tb_biquad_iir_filter;
  import biq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RAND_BATCHES   = 40;
  localparam int BATCH_ITEMS    = 26;

  localparam logic [COEF_BITS-1:0] COEF_POS_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_NEG_MAX = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] COEF_HALF    = {4'b0001, {(CF-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          sat;
    logic                          last;
  } filt_out_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    int unsigned                   idx;
    logic [COEF_BITS-1:0]          coef;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
    logic                          known;
    filt_out_t                     want;
  } plan_row_t;

  // DUT ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_BITS-1:0]  s_axis_tdata  = '0;  // [23:0] sample_in
  logic                   s_axis_tlast  = 1'b0;  // last_in_block
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0]  m_axis_tdata;  // [23:0] sample_out
  logic                   m_axis_tuser;  // saturated
  logic                   m_axis_tlast;  // last_out
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [ADDR_BITS-1:0]   paddr         = '0;
  logic [PDATA_BITS-1:0]  pwdata        = '0;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;

  // model state and bookkeeping
  logic signed [COEF_BITS-1:0]  coef_q [NUM_REGS];
  logic signed [STATE_BITS-1:0] z1_q;
  logic signed [STATE_BITS-1:0] z2_q;
  filt_out_t                    filtered_q [$];
  plan_row_t                    plan [$];
  int                           fail_cnt       = 0;
  int                           idle_cycles    = 0;
  int                           src_idle_pct   = 0;
  int                           sink_stall_pct = 0;

  biquad_iir_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Round half up at the coefficient point, clamp to a signed range of the given width
  function automatic logic signed [63:0] round_clamp(input logic signed [127:0] acc,
                                                     input int bits, inout logic clip);
    logic signed [127:0] s;
    logic signed [127:0] top;
    logic signed [127:0] bot;
    s   = (acc + (128'sd1 <<< (CF - 1))) >>> CF;
    top = (128'sd1 <<< (bits - 1)) - 128'sd1;
    bot = -top - 128'sd1;
    if (s > top) begin
      clip = 1'b1;
      return top[63:0];
    end
    if (s < bot) begin
      clip = 1'b1;
      return bot[63:0];
    end
    return s[63:0];
  endfunction

  // One direct form II step: w = x - fb1*z1 - fb2*z2, y = ff0*w + ff1*z1 + ff2*z2
  function automatic filt_out_t biquad_predict(input logic signed [SAMPLE_BITS-1:0] x,
                                               input logic last);
    logic signed [127:0] xs, z1, z2, w, acc;
    logic signed [127:0] fb1, fb2, ff0, ff1, ff2;
    logic signed [63:0]  y;
    logic                clip;
    filt_out_t           r;
    clip = 1'b0;
    xs   = x;
    z1   = z1_q;
    z2   = z2_q;
    fb1  = coef_q[REG_FB1];
    fb2  = coef_q[REG_FB2];
    ff0  = coef_q[REG_FF0];
    ff1  = coef_q[REG_FF1];
    ff2  = coef_q[REG_FF2];
    acc  = (xs <<< CF) - fb1 * z1 - fb2 * z2;
    w    = round_clamp(acc, STATE_BITS, clip);
    acc  = ff0 * w + ff1 * z1 + ff2 * z2;
    y    = round_clamp(acc, SAMPLE_BITS, clip);
    z2_q = z1_q;
    z1_q = w[STATE_BITS-1:0];
    r.smp  = y[SAMPLE_BITS-1:0];
    r.sat  = clip;
    r.last = last;
    return r;
  endfunction

  // Any in-range coefficient write also clears the delay line
  function automatic void coef_write(input int unsigned idx, input logic [COEF_BITS-1:0] val);
    if (idx < NUM_REGS) begin
      coef_q[idx] = val;
      z1_q = '0;
      z2_q = '0;
    end
  endfunction

  function automatic void add_cfg(input int unsigned idx, input logic [COEF_BITS-1:0] val);
    plan_row_t r;
    r      = '{kind: ROW_CFG, default: '0};
    r.idx  = idx;
    r.coef = val;
    plan.push_back(r);
  endfunction

  function automatic void add_smp(input logic signed [SAMPLE_BITS-1:0] x, input logic last,
                                  input logic known, input logic signed [SAMPLE_BITS-1:0] y,
                                  input logic sat);
    plan_row_t r;
    r       = '{kind: ROW_SMP, default: '0};
    r.smp   = x;
    r.last  = last;
    r.known = known;
    r.want  = '{smp: y, sat: sat, last: last};
    plan.push_back(r);
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COEF_POS_MAX;
      2:       return COEF_NEG_MAX;
      3:       return COEF_ONE;
      4:       return -COEF_ONE;
      5, 6:    return $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;  // within +-1.0
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SMP_TOP;
      1:       return SMP_BOT;
      2:       return SAMPLE_BITS'($urandom_range(64) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Stop feeding and wait until every predicted output has been seen
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  // APB write once every predicted output is seen: setup cycle, access cycle, then bus idle
  task automatic apb_write(input int unsigned idx, input logic [COEF_BITS-1:0] val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    coef_write(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Input transfer with optional leading gaps; expectation queued on acceptance
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic last,
                             input logic known, input filt_out_t want);
    filt_out_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = biquad_predict(x, last);
    filtered_q.push_back(known ? want : pred);
  endtask

  // Output side: check each transfer, randomize backpressure
  always @(posedge clk_i) begin : out_check
    filt_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected output transfer: sample_out %0d",
               $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
        fail_cnt++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.smp) begin
          $error("sample_out: expected %0d, got %0d", $signed(want.smp),
                 $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
          fail_cnt++;
        end
        if (m_axis_tuser !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) coef_q[i] = '0;
    z1_q = '0;
    z2_q = '0;

    // all coefficients zero out of reset: output is zero whatever comes in
    add_smp(0, 1'b0, 1'b1, 0, 1'b0);
    add_smp(SMP_TOP, 1'b1, 1'b1, 0, 1'b0);
    add_smp(SMP_BOT, 1'b0, 1'b1, 0, 1'b0);
    // unity gain passes the sample through
    add_cfg(REG_FF0, COEF_ONE);
    add_smp(SMP_TOP, 1'b0, 1'b1, SMP_TOP, 1'b0);
    add_smp(SMP_BOT, 1'b1, 1'b1, SMP_BOT, 1'b0);
    add_smp(-1, 1'b0, 1'b1, -1, 1'b0);
    // half gain: ties round toward +inf
    add_cfg(REG_FF0, COEF_HALF);
    add_smp(1, 1'b0, 1'b1, 1, 1'b0);
    add_smp(-1, 1'b0, 1'b1, 0, 1'b0);
    add_smp(-3, 1'b1, 1'b1, -1, 1'b0);
    // gain near +4 clips the output
    add_cfg(REG_FF0, COEF_POS_MAX);
    add_smp(SMP_TOP, 1'b0, 1'b1, SMP_TOP, 1'b1);
    add_smp(SMP_BOT, 1'b1, 1'b1, SMP_BOT, 1'b1);
    add_smp(0, 1'b0, 1'b1, 0, 1'b0);
    // gain -4 clips to the opposite rail
    add_cfg(REG_FF0, COEF_NEG_MAX);
    add_smp(SMP_BOT, 1'b0, 1'b1, SMP_TOP, 1'b1);
    add_smp(SMP_TOP, 1'b0, 1'b1, SMP_BOT, 1'b1);
    // runaway feedback: w grows until the delay word clips
    add_cfg(REG_FB1, COEF_NEG_MAX);
    for (int i = 0; i < 5; i++) add_smp(SMP_TOP, i == 4, 1'b0, 0, 1'b0);
    // unmapped register: write dropped, delays survive
    add_cfg(NUM_REGS, 32'h1234_5678);
    add_smp(0, 1'b0, 1'b0, 0, 1'b0);
    add_cfg(REG_FB2, COEF_POS_MAX);
    add_cfg(REG_FF1, COEF_NEG_MAX);
    add_cfg(REG_FF2, COEF_POS_MAX);
    add_smp(24'h555555, 1'b0, 1'b0, 0, 1'b0);
    add_smp(24'hAAAAAA, 1'b1, 1'b0, 0, 1'b0);
    add_smp(SMP_BOT, 1'b0, 1'b0, 0, 1'b0);
    // rewriting an unchanged value still clears the delays
    add_cfg(REG_FF2, COEF_POS_MAX);
    add_smp(0, 1'b1, 1'b1, 0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        apb_write(plan[i].idx, plan[i].coef);
      end else begin
        send_sample(plan[i].smp, plan[i].last, plan[i].known, plan[i].want);
      end
    end

    // random batches, each rewriting a random subset of coefficients, idling pattern set by batch % 4
    for (int b = 0; b < RAND_BATCHES; b++) begin
      case (b % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 46; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 46; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      for (int r = 0; r < NUM_REGS; r++) begin
        if ($urandom_range(1)) apb_write(r, pick_coef());
      end
      if ($urandom_range(7) == 0) apb_write(NUM_REGS + $urandom_range(2), $urandom);
      repeat (BATCH_ITEMS) send_sample(pick_sample(), $urandom_range(7) == 0, 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
